[hdl/mrrc_pkg.sv]
`timescale 1ns / 1ps

package mrrc_pkg;

  // Reflected CRC-16 as used on Modbus RTU links.
  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Byte positions inside the nine-byte read reply.
  localparam int unsigned IDX_W = 4;
  localparam logic [IDX_W-1:0] IDX_CRC_END  = 4'd7;  // first byte outside the CRC
  localparam logic [IDX_W-1:0] IDX_TEMP_HI  = 4'd3;
  localparam logic [IDX_W-1:0] IDX_TEMP_LO  = 4'd4;
  localparam logic [IDX_W-1:0] IDX_HUM_HI   = 4'd5;
  localparam logic [IDX_W-1:0] IDX_HUM_LO   = 4'd6;
  localparam logic [IDX_W-1:0] IDX_CRC_LO   = 4'd7;
  localparam logic [IDX_W-1:0] IDX_LAST     = 4'd8;
  localparam logic [IDX_W-1:0] IDX_DONE     = 4'd9;

  // Input command codes.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_BYTE  = 1'b1;

endpackage

[hdl/mrrc_crc_byte.sv]
`timescale 1ns / 1ps

module mrrc_crc_byte
  import mrrc_pkg::*;
(
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);

  // Eight bit steps of the LSB-first CRC, unrolled into one byte update.
  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data_in};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

[hdl/modbus_read_response_checker.sv]
`timescale 1ns / 1ps
// Path: a word accepted on the input is held in the input register; when it leaves
// that register, the last byte of a frame loads the result register.
// Throughput: one input word per cycle; the only limit is the output stall.
// Reset (rst_n low, synchronous): both pipeline registers empty, byte index 0 and
// the running CRC seeded to 0xFFFF, as if a start command had just been taken.

module modbus_read_response_checker
  import mrrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input channel: one command or received byte per word.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_rx_byte,
  // Result channel: one word per completed reply frame.
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_crc_ok,
  output logic [15:0] out_temperature_raw,
  output logic [15:0] out_humidity_raw,
  output logic [15:0] out_computed_crc,
  output logic [15:0] out_received_crc
);

  // Input register stage. It holds one word and is the pipeline's skid point: while
  // empty it can take a word even when the result register holds an untaken result.
  logic             s1_valid_r;
  logic             s1_cmd_r;
  logic [7:0]       s1_byte_r;

  // Frame state, updated when the word in the input register is processed.
  logic [IDX_W-1:0] byte_idx_r,  byte_idx_nxt;
  logic [15:0]      crc_r,       crc_nxt;
  logic [15:0]      temp_r,      temp_nxt;
  logic [15:0]      hum_r,       hum_nxt;
  logic [7:0]       crc_lo_r,    crc_lo_nxt;

  // Result register.
  logic             out_valid_r;
  logic             out_crc_ok_r;
  logic [15:0]      out_temp_r;
  logic [15:0]      out_hum_r;
  logic [15:0]      out_ccrc_r;
  logic [15:0]      out_rcrc_r;

  logic             s1_adv;
  logic             in_accept;
  logic             s1_fire;
  logic             emit;
  logic [15:0]      crc_step;
  logic [15:0]      rx_crc;

  // The input register moves on whenever the result register is free or is
  // being emptied in this cycle.
  assign s1_adv    = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;
  assign s1_fire   = s1_valid_r && s1_adv;

  mrrc_crc_byte u_crc (
    .crc_in  (crc_r),
    .data_in (s1_byte_r),
    .crc_out (crc_step)
  );

  // The received CRC travels low byte first, so byte 8 is its high byte.
  assign rx_crc = {s1_byte_r, crc_lo_r};
  assign emit   = s1_fire && (s1_cmd_r == CMD_BYTE) && (byte_idx_r == IDX_LAST);

  always_comb begin
    byte_idx_nxt = byte_idx_r;
    crc_nxt      = crc_r;
    temp_nxt     = temp_r;
    hum_nxt      = hum_r;
    crc_lo_nxt   = crc_lo_r;
    if (s1_fire) begin
      if (s1_cmd_r == CMD_START) begin
        // A start command reopens the frame; captured words stay until overwritten.
        byte_idx_nxt = '0;
        crc_nxt      = CRC_SEED;
      end else if (byte_idx_r <= IDX_LAST) begin
        // Bytes past the end of a frame are dropped until the next start.
        if (byte_idx_r < IDX_CRC_END) begin
          crc_nxt = crc_step;
        end
        case (byte_idx_r)
          IDX_TEMP_HI: temp_nxt   = {s1_byte_r, temp_r[7:0]};
          IDX_TEMP_LO: temp_nxt   = {temp_r[15:8], s1_byte_r};
          IDX_HUM_HI:  hum_nxt    = {s1_byte_r, hum_r[7:0]};
          IDX_HUM_LO:  hum_nxt    = {hum_r[15:8], s1_byte_r};
          IDX_CRC_LO:  crc_lo_nxt = s1_byte_r;
          default:     ;
        endcase
        if (byte_idx_r == IDX_LAST) begin
          byte_idx_nxt = IDX_DONE;
        end else begin
          byte_idx_nxt = byte_idx_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      byte_idx_r  <= '0;
      crc_r       <= CRC_SEED;
      temp_r      <= '0;
      hum_r       <= '0;
      crc_lo_r    <= '0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      byte_idx_r <= byte_idx_nxt;
      crc_r      <= crc_nxt;
      temp_r     <= temp_nxt;
      hum_r      <= hum_nxt;
      crc_lo_r   <= crc_lo_nxt;
    end
  end

  // Payload registers carry no reset; they load only with their valid.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cmd_r  <= in_command;
      s1_byte_r <= in_rx_byte;
    end
    if (emit) begin
      out_crc_ok_r <= (rx_crc == crc_r);
      out_temp_r   <= temp_r;
      out_hum_r    <= hum_r;
      out_ccrc_r   <= crc_r;
      out_rcrc_r   <= rx_crc;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_crc_ok          = out_crc_ok_r;
  assign out_temperature_raw = out_temp_r;
  assign out_humidity_raw    = out_hum_r;
  assign out_computed_crc    = out_ccrc_r;
  assign out_received_crc    = out_rcrc_r;

  // The byte index never runs past the end-of-frame mark.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_idx_r <= IDX_DONE)
    else $error("byte index beyond end of frame");

  // A start command reseeds the CRC and rewinds the index.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_cmd_r == CMD_START) |=> (byte_idx_r == '0 && crc_r == CRC_SEED))
    else $error("start command did not reopen the frame");

  // The last byte of a frame produces a result and closes the frame.
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (out_valid_r && byte_idx_r == IDX_DONE))
    else $error("frame end did not load a result");

  // The check flag agrees with the two CRCs it was formed from.
  a_crc_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_crc_ok_r == (out_ccrc_r == out_rcrc_r)))
    else $error("crc_ok inconsistent with reported CRCs");

  // The input side only stalls while a word sits in the input register.
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with free pipeline");

endmodule

[test/modbus_reply_monitor.sv]
`timescale 1ns / 1ps

module modbus_reply_monitor
  import mrrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_crc_ok,
  input  logic [15:0] out_temperature_raw,
  input  logic [15:0] out_humidity_raw,
  input  logic [15:0] out_computed_crc,
  input  logic [15:0] out_received_crc,
  output int          error_count,
  output int          replies_pending
);

  typedef struct packed {
    logic        crc_ok;
    logic [15:0] temperature;
    logic [15:0] humidity;
    logic [15:0] computed_crc;
    logic [15:0] received_crc;
  } reply_t;

  reply_t expected_replies[$];

  // Shadow of the frame decoder.
  logic [IDX_W-1:0] byte_pos;
  logic [15:0]      crc_acc;
  logic [15:0]      temp_word;
  logic [15:0]      hum_word;
  logic [7:0]       crc_lo;
  logic             frame_done;

  initial begin
    error_count     = 0;
    replies_pending = 0;
  end

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%h, got 0x%h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    reply_t want_r;
    logic [15:0] rx_crc;
    if (!rst_n) begin
      byte_pos   = '0;
      crc_acc    = CRC_SEED;
      temp_word  = '0;
      hum_word   = '0;
      crc_lo     = '0;
      frame_done = 1'b0;
      expected_replies.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          $error("result word with no reply expected");
          error_count++;
        end else begin
          want_r = expected_replies.pop_front();
          check_field("crc_ok", 16'(want_r.crc_ok), 16'(out_crc_ok));
          check_field("temperature_raw", want_r.temperature, out_temperature_raw);
          check_field("humidity_raw", want_r.humidity, out_humidity_raw);
          check_field("computed_crc", want_r.computed_crc, out_computed_crc);
          check_field("received_crc", want_r.received_crc, out_received_crc);
        end
      end

      if (in_valid && !in_stall) begin
        if (in_command == CMD_START) begin
          byte_pos   = '0;
          crc_acc    = CRC_SEED;
          frame_done = 1'b0;
        end else if (!frame_done && byte_pos <= IDX_LAST) begin
          if (byte_pos < IDX_CRC_END) crc_acc = crc16_byte(crc_acc, in_rx_byte);
          case (byte_pos)
            IDX_TEMP_HI: temp_word[15:8] = in_rx_byte;
            IDX_TEMP_LO: temp_word[7:0]  = in_rx_byte;
            IDX_HUM_HI:  hum_word[15:8]  = in_rx_byte;
            IDX_HUM_LO:  hum_word[7:0]   = in_rx_byte;
            IDX_CRC_LO:  crc_lo          = in_rx_byte;
            default: ;
          endcase
          if (byte_pos == IDX_LAST) begin
            rx_crc              = {in_rx_byte, crc_lo};
            want_r.crc_ok       = (rx_crc == crc_acc);
            want_r.temperature  = temp_word;
            want_r.humidity     = hum_word;
            want_r.computed_crc = crc_acc;
            want_r.received_crc = rx_crc;
            expected_replies.push_back(want_r);
            frame_done = 1'b1;
            byte_pos   = IDX_DONE;
          end else begin
            byte_pos = byte_pos + 1'b1;
          end
        end
      end
    end
    replies_pending = expected_replies.size();
  end

endmodule

[test/tb_modbus_read_response_checker.sv]
`timescale 1ns / 1ps

// Top of the reply checker bench. This module only makes stimulus and decides the
// verdict; the monitor beside the block predicts every reply and compares it.
module tb_modbus_read_response_checker;
  import mrrc_pkg::*;

  // Stimulus stops once roughly this many input words have been accepted.
  localparam int WORD_TARGET  = 1700;
  // Cycles without any accepted word before the run is declared hung.
  localparam int IDLE_LIMIT   = 5000;
  // Extra wait after the last predicted reply, so a stray result can show up.
  localparam int DRAIN_CYCLES = 10;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_command;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic        out_crc_ok;
  logic [15:0] out_temperature_raw;
  logic [15:0] out_humidity_raw;
  logic [15:0] out_computed_crc;
  logic [15:0] out_received_crc;

  int error_count;
  int replies_pending;

  int burst_left  = 0;
  int words_sent  = 0;
  int idle_cycles = 0;
  int stall_left  = 0;
  int stall_mode  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  modbus_read_response_checker DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_crc_ok          (out_crc_ok),
    .out_temperature_raw (out_temperature_raw),
    .out_humidity_raw    (out_humidity_raw),
    .out_computed_crc    (out_computed_crc),
    .out_received_crc    (out_received_crc)
  );

  modbus_reply_monitor u_monitor (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_crc_ok          (out_crc_ok),
    .out_temperature_raw (out_temperature_raw),
    .out_humidity_raw    (out_humidity_raw),
    .out_computed_crc    (out_computed_crc),
    .out_received_crc    (out_received_crc),
    .error_count         (error_count),
    .replies_pending     (replies_pending)
  );

  // The result side stalls on its own pattern. Every so often it picks a new
  // mode: never stall, stall now and then, or stall most of the time. The first
  // mode gives long stretches where replies drain at full rate.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // Watchdog: any accepted word on either side resets the idle count. A block
  // that stops moving words ends the run as a failure.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // CRC step used only to build the checksum bytes of the generated replies.
  function automatic logic [15:0] reply_crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Random register value with the extremes showing up more often than chance.
  function automatic logic [15:0] rand_reg_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Send one word. The sender works in bursts: when a burst runs out, valid drops
  // for a random gap (sometimes none) and a new burst length is drawn. Valid is
  // only lowered when a gap actually follows, so it never toggles within a step.
  task automatic send_word(input logic cmd, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_rx_byte <= b;
    // The stall seen right after the edge is the value the block had at the edge.
    do @(posedge clk); while (in_stall);
    burst_left--;
    words_sent++;
  endtask

  // Build a nine-byte read reply and send its first n_bytes. Half of the replies
  // use a realistic header (slave address, function 3, byte count 4); the rest
  // use a random header so the CRC sees arbitrary leading bytes. A bad reply has
  // one bit flipped in one of the two checksum bytes.
  task automatic send_reply(input logic [15:0] temp, input logic [15:0] hum,
                            input bit crc_good, input int n_bytes);
    logic [7:0]  frame [0:8];
    logic [15:0] crc;
    int          i;
    int          hit;
    if ($urandom_range(0, 1) == 1) begin
      frame[0] = 8'($urandom_range(1, 247));
      frame[1] = 8'h03;
      frame[2] = 8'h04;
    end else begin
      frame[0] = 8'($urandom);
      frame[1] = 8'($urandom);
      frame[2] = 8'($urandom);
    end
    frame[3] = temp[15:8];
    frame[4] = temp[7:0];
    frame[5] = hum[15:8];
    frame[6] = hum[7:0];
    crc = CRC_SEED;
    for (i = 0; i < 7; i++) crc = reply_crc_step(crc, frame[i]);
    frame[7] = crc[7:0];
    frame[8] = crc[15:8];
    if (!crc_good) begin
      hit = 7 + $urandom_range(0, 1);
      frame[hit] = frame[hit] ^ (8'h01 << $urandom_range(0, 7));
    end
    for (i = 0; i < n_bytes; i++) send_word(CMD_BYTE, frame[i]);
  endtask

  initial begin
    int pick;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_command <= CMD_START;
    in_rx_byte <= 8'h00;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Straight out of reset the block acts as if a frame had just
    // been started, so a full reply without a start must still produce a result.
    send_reply(16'hFFFF, 16'h0000, 1'b1, 9);
    // A byte after the ninth is ignored until the next start.
    send_word(CMD_BYTE, 8'hFF);
    // A start carries a byte that the block must ignore.
    send_word(CMD_START, 8'hFF);
    // Reply with a corrupted checksum and opposite extremes in the data words.
    send_reply(16'h0000, 16'hFFFF, 1'b0, 9);
    // A start that opens a frame which is abandoned after three bytes.
    send_word(CMD_START, 8'h00);
    send_reply(16'h8000, 16'h0001, 1'b1, 3);
    // A further start right after the abandoned frame.
    send_word(CMD_START, 8'hA5);

    // Random part. Most of the traffic is well-formed replies with random
    // content; the rest is abandoned frames, replies with no start in front
    // (ignored after a finished frame, continued after an abandoned one) and
    // plain noise with random commands.
    while (words_sent < WORD_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        send_word(CMD_START, 8'($urandom));
        send_reply(rand_reg_word(), rand_reg_word(), $urandom_range(0, 3) != 0, 9);
      end else if (pick < 85) begin
        send_word(CMD_START, 8'($urandom));
        send_reply(rand_reg_word(), rand_reg_word(), 1'b1, $urandom_range(0, 8));
      end else if (pick < 92) begin
        send_reply(rand_reg_word(), rand_reg_word(), $urandom_range(0, 1) != 0, 9);
      end else begin
        repeat ($urandom_range(1, 6)) send_word(1'($urandom_range(0, 1)), 8'($urandom));
      end
    end
    in_valid <= 1'b0;

    // Wait for every predicted reply to come out, then wait DRAIN_CYCLES more so
    // that any stray result can show up before the verdict.
    do @(posedge clk); while (replies_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (replies_pending != 0) $error("%0d expected replies never arrived", replies_pending);
    if (error_count == 0 && replies_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
